/* src/pdt_pkg.sv */
// Shared types, constants and helpers for the paired device table.
// Used by paired_device_table and the testbench; depends on nothing.
`default_nettype none
package pdt_pkg;

  parameter int ENTRIES = 8;
  parameter int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  parameter int CNT_W = $clog2(ENTRIES + 1);
  parameter logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

  parameter logic [2:0] ACT_ADD = 3'd0;
  parameter logic [2:0] ACT_REMOVE = 3'd1;
  parameter logic [2:0] ACT_TOUCH = 3'd2;
  parameter logic [2:0] ACT_LOOKUP = 3'd3;
  parameter logic [2:0] ACT_RECONNECT = 3'd4;
  parameter logic [2:0] ACT_CLEAR = 3'd5;

  parameter logic [1:0] ST_OK = 2'd0;
  parameter logic [1:0] ST_FULL = 2'd1;
  parameter logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [47:0] addr;
    logic [23:0] class_code;
    logic        hands_free;
    logic [31:0] stamp;
    logic [31:0] connections;
  } entry_t;

  parameter int ENTRY_W = $bits(entry_t);

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [2:0] slot_of(input logic [IDX_W-1:0] i);
    logic [IDX_W+2:0] w;
    w = {3'b000, i};
    return w[2:0];
  endfunction

  function automatic logic [3:0] used_of(input logic [CNT_W-1:0] c);
    logic [CNT_W+3:0] w;
    w = {4'b0000, c};
    return w[3:0];
  endfunction

endpackage
`default_nettype wire

/* src/pdt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module pdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/paired_device_table.sv */
// Paired device table: entries held in one RAM, searched and shifted by a small sequencer.
// done follows start in the next cycle for clear, unused actions and add to a full table.
// A search reads then compares each entry in turn, then resolves; reconnect and any miss visit
// every entry, and a remove that hits shifts each later entry down. One transaction at a time:
// busy holds until done, the next start is taken in the done cycle; the receiver cannot stall.
// Reset: entry count cleared synchronously; RAM contents stay undefined. Depends on pdt_pkg, pdt_ram.
`default_nettype none
module paired_device_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  action,
  input  wire logic [47:0] addr,
  input  wire logic [23:0] class_code,
  input  wire logic        hands_free,
  input  wire logic [31:0] now,
  output logic             done,
  output logic [1:0]       status,
  output logic [2:0]       slot,
  output logic [47:0]      out_addr,
  output logic [23:0]      out_class,
  output logic             out_hands_free,
  output logic [31:0]      out_time,
  output logic [31:0]      out_connections,
  output logic [3:0]       used
);

  localparam int IDX_W = pdt_pkg::IDX_W;
  localparam int CNT_W = pdt_pkg::CNT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CMP = 3'd2;
  localparam logic [2:0] S_RESOLVE = 3'd3;
  localparam logic [2:0] S_SH_READ = 3'd4;
  localparam logic [2:0] S_SH_WRITE = 3'd5;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] idx_m1;
  logic             found, found_next;
  pdt_pkg::entry_t  hit, hit_next;
  logic [IDX_W-1:0] hit_idx, hit_idx_next;
  logic [31:0]      best_time, best_time_next;
  logic [2:0]       op;
  logic [47:0]      key;
  logic [23:0]      cls;
  logic             hf;
  logic [31:0]      stamp;

  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  pdt_pkg::entry_t             ram_wdata;
  logic [IDX_W-1:0]            ram_raddr;
  logic [pdt_pkg::ENTRY_W-1:0] ram_rdata;
  pdt_pkg::entry_t             rd;
  pdt_pkg::entry_t             upd;

  logic             emit;
  logic             res_show;
  logic [1:0]       res_status;
  pdt_pkg::entry_t  res_entry;
  logic [IDX_W-1:0] res_idx;

  assign busy = (state != S_IDLE);
  assign rd = pdt_pkg::entry_t'(ram_rdata);
  assign idx_m1 = idx - 1'b1;

  pdt_ram #(
    .WIDTH(pdt_pkg::ENTRY_W),
    .DEPTH(pdt_pkg::ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    if ((op == pdt_pkg::ACT_ADD) && !found) begin
      upd = '{addr: key, class_code: cls, hands_free: hf, stamp: stamp,
              connections: 32'd1};
    end else begin
      upd = hit;
      if (op == pdt_pkg::ACT_ADD) begin
        upd.class_code = cls;
        upd.hands_free = hf;
      end
      upd.stamp = stamp;
      upd.connections = pdt_pkg::sat_inc(hit.connections);
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next = idx;
    found_next = found;
    hit_next = hit;
    hit_idx_next = hit_idx;
    best_time_next = best_time;
    ram_we = 1'b0;
    ram_waddr = hit_idx;
    ram_wdata = upd;
    ram_raddr = idx[IDX_W-1:0];
    emit = 1'b0;
    res_show = 1'b0;
    res_status = pdt_pkg::ST_OK;
    res_entry = hit;
    res_idx = hit_idx;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          idx_next = '0;
          found_next = 1'b0;
          best_time_next = '0;
          case (action)
            pdt_pkg::ACT_ADD: begin
              if (count >= pdt_pkg::FULL_COUNT) begin
                emit = 1'b1;
                res_status = pdt_pkg::ST_FULL;
              end else begin
                state_next = S_READ;
              end
            end
            pdt_pkg::ACT_REMOVE, pdt_pkg::ACT_TOUCH, pdt_pkg::ACT_LOOKUP,
            pdt_pkg::ACT_RECONNECT: begin
              state_next = S_READ;
            end
            pdt_pkg::ACT_CLEAR: begin
              count_next = '0;
              emit = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        state_next = (idx == count) ? S_RESOLVE : S_CMP;
      end
      S_CMP: begin
        if (op == pdt_pkg::ACT_RECONNECT) begin
          if (rd.hands_free && (rd.stamp > best_time)) begin
            best_time_next = rd.stamp;
            hit_next = rd;
            hit_idx_next = idx[IDX_W-1:0];
            found_next = 1'b1;
          end
          idx_next = idx + 1'b1;
          state_next = S_READ;
        end else if (rd.addr == key) begin
          hit_next = rd;
          hit_idx_next = idx[IDX_W-1:0];
          found_next = 1'b1;
          state_next = S_RESOLVE;
        end else begin
          idx_next = idx + 1'b1;
          state_next = S_READ;
        end
      end
      S_RESOLVE: begin
        state_next = S_IDLE;
        case (op)
          pdt_pkg::ACT_ADD: begin
            ram_we = 1'b1;
            ram_waddr = found ? hit_idx : count[IDX_W-1:0];
            count_next = found ? count : count + 1'b1;
            emit = 1'b1;
            res_show = 1'b1;
            res_entry = upd;
            res_idx = ram_waddr;
          end
          pdt_pkg::ACT_TOUCH: begin
            emit = 1'b1;
            if (found) begin
              ram_we = 1'b1;
              res_show = 1'b1;
              res_entry = upd;
            end else begin
              res_status = pdt_pkg::ST_NOT_FOUND;
            end
          end
          pdt_pkg::ACT_REMOVE: begin
            if (found) begin
              idx_next = CNT_W'(hit_idx) + 1'b1;
              state_next = S_SH_READ;
            end else begin
              emit = 1'b1;
              res_status = pdt_pkg::ST_NOT_FOUND;
            end
          end
          default: begin
            emit = 1'b1;
            res_show = found;
            res_status = found ? pdt_pkg::ST_OK : pdt_pkg::ST_NOT_FOUND;
          end
        endcase
      end
      S_SH_READ: begin
        if (idx == count) begin
          count_next = count - 1'b1;
          emit = 1'b1;
          res_show = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_SH_WRITE;
        end
      end
      S_SH_WRITE: begin
        ram_we = 1'b1;
        ram_waddr = idx_m1[IDX_W-1:0];
        ram_wdata = rd;
        idx_next = idx + 1'b1;
        state_next = S_SH_READ;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done <= emit;
    end
    idx <= idx_next;
    found <= found_next;
    hit <= hit_next;
    hit_idx <= hit_idx_next;
    best_time <= best_time_next;
    if ((state == S_IDLE) && start) begin
      op <= action;
      key <= addr;
      cls <= class_code;
      hf <= hands_free;
      stamp <= now;
    end
    if (emit) begin
      status <= res_status;
      used <= pdt_pkg::used_of(count_next);
      if (res_show) begin
        slot <= pdt_pkg::slot_of(res_idx);
        out_addr <= res_entry.addr;
        out_class <= res_entry.class_code;
        out_hands_free <= res_entry.hands_free;
        out_time <= res_entry.stamp;
        out_connections <= res_entry.connections;
      end else begin
        slot <= '0;
        out_addr <= '0;
        out_class <= '0;
        out_hands_free <= 1'b0;
        out_time <= '0;
        out_connections <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pdt_pkg::FULL_COUNT)
    else $error("entry count above table size");

  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start) && !$past(busy)) || $past(busy))
    else $error("result without a transaction");

  a_full_reports_full: assert property (@(posedge clk) disable iff (rst)
    (done && (status == pdt_pkg::ST_FULL)) |->
      (used == pdt_pkg::used_of(pdt_pkg::FULL_COUNT)))
    else $error("full status with a table that is not full");

  a_write_while_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> busy)
    else $error("RAM write outside a transaction");

endmodule
`default_nettype wire

/* dv/pdt_tb_pkg.sv */
// Scoreboard for the paired device table testbench: predicts each reply and checks the DUT's.
// Depends on pdt_pkg for the entry layout, action and status codes.
package pdt_tb_pkg;
  import pdt_pkg::*;

  parameter logic [2:0] ACT_SPARE6 = 3'd6;
  parameter logic [2:0] ACT_SPARE7 = 3'd7;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] slot;
    entry_t     entry;
    logic [3:0] used;
  } table_reply_t;

  class table_scoreboard;
    entry_t       slots [ENTRIES];
    int           live;
    table_reply_t pending_replies [$];
    int unsigned  errors;
    int unsigned  replies_seen;

    function new();
      live = 0;
      errors = 0;
      replies_seen = 0;
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction

    function void note_request(logic [2:0] act, logic [47:0] a, logic [23:0] cls, logic hf,
                               logic [31:0] t);
      table_reply_t r;
      int           hit;
      logic [31:0]  best;
      r = '0;
      r.status = ST_OK;
      hit = -1;
      for (int i = 0; i < live; i++) begin
        if (hit < 0 && slots[i].addr == a) hit = i;
      end
      case (act)
        ACT_ADD: begin
          if (live >= ENTRIES) begin
            r.status = ST_FULL;
          end else begin
            if (hit < 0) begin
              hit = live;
              slots[hit].addr = a;
              slots[hit].connections = 32'd1;
              live++;
            end else if (slots[hit].connections != 32'hFFFF_FFFF) begin
              slots[hit].connections = slots[hit].connections + 32'd1;
            end
            slots[hit].class_code = cls;
            slots[hit].hands_free = hf;
            slots[hit].stamp = t;
            r.slot = 3'(hit);
            r.entry = slots[hit];
          end
        end
        ACT_REMOVE: begin
          if (hit < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.slot = 3'(hit);
            r.entry = slots[hit];
            for (int j = hit; j + 1 < live; j++) slots[j] = slots[j + 1];
            live--;
          end
        end
        ACT_TOUCH: begin
          if (hit < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            slots[hit].stamp = t;
            if (slots[hit].connections != 32'hFFFF_FFFF)
              slots[hit].connections = slots[hit].connections + 32'd1;
            r.slot = 3'(hit);
            r.entry = slots[hit];
          end
        end
        ACT_LOOKUP: begin
          if (hit < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.slot = 3'(hit);
            r.entry = slots[hit];
          end
        end
        ACT_RECONNECT: begin
          best = 32'd0;
          hit = -1;
          for (int i = 0; i < live; i++) begin
            if (slots[i].hands_free && slots[i].stamp > best) begin
              best = slots[i].stamp;
              hit = i;
            end
          end
          if (hit < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.slot = 3'(hit);
            r.entry = slots[hit];
          end
        end
        ACT_CLEAR: begin
          live = 0;
        end
        default: begin
        end
      endcase
      r.used = 4'(live);
      pending_replies.push_back(r);
    endfunction

    task report(string field, logic [63:0] seen, logic [63:0] want);
      $display("reply %0d: %s mismatch, got %0h, expected %0h", replies_seen, field, seen, want);
      errors++;
    endtask

    task check_result(table_reply_t seen);
      table_reply_t want;
      replies_seen++;
      if (pending_replies.size() == 0) begin
        report("unexpected transaction", 64'd1, 64'd0);
        return;
      end
      want = pending_replies.pop_front();
      if (seen.status !== want.status)
        report("status", 64'(seen.status), 64'(want.status));
      if (seen.slot !== want.slot) report("slot", 64'(seen.slot), 64'(want.slot));
      if (seen.entry.addr !== want.entry.addr)
        report("out_addr", 64'(seen.entry.addr), 64'(want.entry.addr));
      if (seen.entry.class_code !== want.entry.class_code)
        report("out_class", 64'(seen.entry.class_code), 64'(want.entry.class_code));
      if (seen.entry.hands_free !== want.entry.hands_free)
        report("out_hands_free", 64'(seen.entry.hands_free), 64'(want.entry.hands_free));
      if (seen.entry.stamp !== want.entry.stamp)
        report("out_time", 64'(seen.entry.stamp), 64'(want.entry.stamp));
      if (seen.entry.connections !== want.entry.connections)
        report("out_connections", 64'(seen.entry.connections), 64'(want.entry.connections));
      if (seen.used !== want.used) report("used", 64'(seen.used), 64'(want.used));
    endtask
  endclass

endpackage

/* dv/tb_paired_device_table.sv */
// Top-level testbench for paired_device_table: directed table operations, then random traffic.
// Depends on pdt_pkg, pdt_tb_pkg and the paired_device_table RTL.
module tb_paired_device_table;
  timeunit 1ns;
  timeprecision 1ps;

  import pdt_pkg::*;
  import pdt_tb_pkg::*;

  localparam int RANDOM_ITEMS = 1275;
  localparam int CALM_FROM = 1000;
  localparam int STALL_LIMIT = 2000;
  localparam int POOL_SIZE = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  action = ACT_LOOKUP;
  logic [47:0] addr = '0;
  logic [23:0] class_code = '0;
  logic        hands_free = 1'b0;
  logic [31:0] now = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [2:0]  slot;
  logic [47:0] out_addr;
  logic [23:0] out_class;
  logic        out_hands_free;
  logic [31:0] out_time;
  logic [31:0] out_connections;
  logic [3:0]  used;

  table_scoreboard book;
  table_reply_t    seen_reply;
  int              quiet_cycles = 0;

  paired_device_table i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .addr(addr), .class_code(class_code), .hands_free(hands_free), .now(now),
    .done(done), .status(status), .slot(slot), .out_addr(out_addr), .out_class(out_class),
    .out_hands_free(out_hands_free), .out_time(out_time), .out_connections(out_connections),
    .used(used)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  assign seen_reply = {status, slot, out_addr, out_class, out_hands_free, out_time,
                       out_connections, used};

  always @(posedge clk) begin
    if (!rst && done) book.check_result(seen_reply);
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_paired_device_table: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [47:0] rand_addr();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  task automatic issue(logic [2:0] act, logic [47:0] a, logic [23:0] cls, logic hf,
                       logic [31:0] t);
    @(negedge clk);
    start <= 1'b1;
    action <= act;
    addr <= a;
    class_code <= cls;
    hands_free <= hf;
    now <= t;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    book.note_request(act, a, cls, hf, t);
  endtask

  task automatic idle_gap(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (book.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    logic [47:0] pool [POOL_SIZE];
    int          roll;
    logic [2:0]  act;
    logic [47:0] a;
    logic [31:0] t;
    book = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    issue(ACT_LOOKUP, 48'h0000_0000_0123, '0, 1'b0, '0);
    issue(ACT_RECONNECT, '0, '0, 1'b0, '0);
    issue(ACT_REMOVE, 48'h0000_0000_0123, '0, 1'b0, '0);
    issue(ACT_TOUCH, 48'h0000_0000_0123, '0, 1'b0, 32'd9);
    issue(ACT_ADD, '0, '0, 1'b0, '0);
    issue(ACT_ADD, '1, '1, 1'b1, '1);
    issue(ACT_ADD, '0, 24'h5A5A5A, 1'b1, '0);
    issue(ACT_RECONNECT, '0, '0, 1'b0, '0);
    issue(ACT_TOUCH, '0, '0, 1'b0, '1);
    issue(ACT_RECONNECT, '0, '0, 1'b0, '0);
    for (int k = 0; k < 6; k++)
      issue(ACT_ADD, 48'h0000_5A00_0000 + 48'(k), 24'(k * 24'h111111), 1'(k % 2),
            32'(k / 2 * 100));
    issue(ACT_ADD, 48'hAAAA_5555_AAAA, 24'h123456, 1'b1, 32'd7);
    issue(ACT_ADD, '1, 24'h654321, 1'b0, 32'd8);
    issue(ACT_LOOKUP, '1, '0, 1'b0, '0);
    issue(ACT_REMOVE, '0, '0, 1'b0, '0);
    issue(ACT_REMOVE, 48'h0000_5A00_0005, '0, 1'b0, '0);
    issue(ACT_SPARE6, '1, '1, 1'b1, '1);
    issue(ACT_SPARE7, '0, '0, 1'b0, '0);
    issue(ACT_CLEAR, '0, '0, 1'b0, '0);
    issue(ACT_LOOKUP, '1, '0, 1'b0, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        for (int k = 0; k < POOL_SIZE; k++) pool[k] = rand_addr();
      end
      if (n == 400 || n == 900) drain();
      if (n < CALM_FROM && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 4));
      roll = $urandom_range(0, 99);
      if (roll < 35) act = ACT_ADD;
      else if (roll < 50) act = ACT_REMOVE;
      else if (roll < 63) act = ACT_TOUCH;
      else if (roll < 76) act = ACT_LOOKUP;
      else if (roll < 90) act = ACT_RECONNECT;
      else if (roll < 93) act = ACT_CLEAR;
      else if (roll < 96) act = ACT_SPARE6;
      else act = ACT_SPARE7;
      a = ($urandom_range(0, 9) == 0) ? rand_addr() : pool[$urandom_range(0, POOL_SIZE - 1)];
      roll = $urandom_range(0, 9);
      if (roll == 0) t = '0;
      else if (roll < 5) t = 32'($urandom_range(0, 15));
      else if (roll < 9) t = $urandom;
      else t = '1;
      issue(act, a, 24'($urandom), 1'($urandom), t);
    end

    drain();
    repeat (50) @(posedge clk);
    if (book.errors == 0 && book.outstanding() == 0) begin
      $display("tb_paired_device_table: done, clean");
    end else begin
      $display("tb_paired_device_table: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
src/pdt_pkg.sv
src/pdt_ram.sv
src/paired_device_table.sv
dv/pdt_tb_pkg.sv
dv/tb_paired_device_table.sv
